[design/rwsc_pkg.sv]
// ----------------------------------------------------------------------------
// rwsc_pkg: shared types and constants of the rapidity window species counter
// Command codes, species code table, register indexes, bus widths and the
// bundle that passes between the classify stage and the tally stage.
// ----------------------------------------------------------------------------
package rwsc_pkg;

  localparam int NUM_SPECIES_DEF = 25;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int TABLE_LEN       = 25;

  localparam int IN_TDATA_W  = 104;  // 100 bits of fields, padded to bytes
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 72;   // 70 bits of fields, padded to bytes

  localparam int RATIO_W  = 24;
  localparam int Q_FRAC   = 16;
  localparam int LHS_W    = 32 + Q_FRAC;
  localparam int PROD_W   = RATIO_W + 32;
  localparam int EVENT_W  = 32;

  localparam logic [RATIO_W-1:0] RATIO_LOW_RST  = 24'd24109;
  localparam logic [RATIO_W-1:0] RATIO_HIGH_RST = 24'd178145;

  localparam int CFG_ADDR_W = 1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_RATIO_LOW  = 1'b0,
    CFG_RATIO_HIGH = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_PARTICLE  = 2'd0,
    CMD_END_EVENT = 2'd1,
    CMD_READ      = 2'd2,
    CMD_NOP       = 2'd3
  } cmd_t;

  // Species codes by table index; charge conjugates follow the 14 base codes
  localparam logic signed [31:0] SPECIES_CODE [TABLE_LEN] = '{
    32'sd111,   32'sd211,   32'sd311,   32'sd321,   32'sd310,
    32'sd130,   32'sd3122,  32'sd3222,  32'sd3212,  32'sd3112,
    32'sd3322,  32'sd3312,  32'sd3334,  32'sd2212,  -32'sd211,
    -32'sd311,  -32'sd321,  -32'sd3122, -32'sd3222, -32'sd3212,
    -32'sd3112, -32'sd3322, -32'sd3312, -32'sd3334, -32'sd2212
  };

  typedef struct packed {
    cmd_t              cmd;
    logic              hit;      // counter address is valid
    logic              pos;      // E > |pz|
    logic [LHS_W-1:0]  lhs;      // (E+pz) in Q32.16
    logic [PROD_W-1:0] prod_lo;  // ratio_low  * (E-pz)
    logic [PROD_W-1:0] prod_hi;  // ratio_high * (E-pz)
  } rwsc_mid_t;

endpackage

[design/rapidity_window_species_counter.sv]
// ----------------------------------------------------------------------------
// rapidity_window_species_counter: per-species particle counts in a y window
// Counts particles of known species whose rapidity lies in a configurable
// window, counts events and reads back single species counts.
//
//   channel | direction | contents
//   --------+-----------+---------------------------------------------------
//   in_     | slave     | tuser: cmd; tdata: pdg_code, energy, momentum_z,
//           |           |   species_select
//   out_    | master    | tdata: accepted, species_index, count_value,
//           |           |   event_total
//   cfg_    | write     | addr 0 ratio_low, addr 1 ratio_high (Q8.16)
//
// One transaction per cycle while out_tready stays high; a result reaches
// out_tdata through three registers: input register, classify/multiply
// register, result register. The counters are read and written only in the
// last stage, so back-to-back hits on one species need no forwarding.
// A stall on out_tready holds the result register; the earlier stages keep
// filling, and in_tready drops once all three hold a transaction.
// Reset clears all counters.
// ----------------------------------------------------------------------------
module rapidity_window_species_counter #(
  parameter int NUM_SPECIES = rwsc_pkg::NUM_SPECIES_DEF,
  parameter int COUNT_WIDTH = rwsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pdg_code[31:0], energy[62:32], momentum_z[94:63], species_select[99:95]
  input  logic [rwsc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // cmd[1:0]
  input  logic [rwsc_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // accepted[0], species_index[5:1], count_value[37:6], event_total[69:38]
  output logic [rwsc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [rwsc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [rwsc_pkg::RATIO_W-1:0]      cfg_wdata
);
  import rwsc_pkg::*;

  localparam int IDX_W = $clog2(NUM_SPECIES + 1);

  logic [RATIO_W-1:0] ratio_low_r;
  logic [RATIO_W-1:0] ratio_high_r;
  logic               mid_valid;
  logic               mid_ready;
  rwsc_mid_t          mid;
  logic [IDX_W-1:0]   mid_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_low_r  <= RATIO_LOW_RST;
      ratio_high_r <= RATIO_HIGH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_RATIO_LOW:  ratio_low_r  <= cfg_wdata;
        CFG_RATIO_HIGH: ratio_high_r <= cfg_wdata;
      endcase
    end
  end

  rwsc_front #(
    .NUM_SPECIES (NUM_SPECIES),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .ratio_low  (ratio_low_r),
    .ratio_high (ratio_high_r),
    .mid_valid  (mid_valid),
    .mid_ready  (mid_ready),
    .mid        (mid),
    .mid_idx    (mid_idx)
  );

  rwsc_tally #(
    .NUM_SPECIES (NUM_SPECIES),
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W)
  ) u_tally (
    .clk        (clk),
    .rst_n      (rst_n),
    .mid_valid  (mid_valid),
    .mid_ready  (mid_ready),
    .mid        (mid),
    .mid_idx    (mid_idx),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[design/rwsc_front.sv]
// ----------------------------------------------------------------------------
// rwsc_front: input register and classify stage
// Registers the incoming transaction, matches the species code, forms
// E+pz and E-pz and multiplies E-pz by both window ratios.
// ----------------------------------------------------------------------------
module rwsc_front #(
  parameter int NUM_SPECIES = rwsc_pkg::NUM_SPECIES_DEF,
  parameter int IDX_W       = $clog2(NUM_SPECIES + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rwsc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [rwsc_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic [rwsc_pkg::RATIO_W-1:0]     ratio_low,
  input  logic [rwsc_pkg::RATIO_W-1:0]     ratio_high,
  output logic                             mid_valid,
  input  logic                             mid_ready,
  output rwsc_pkg::rwsc_mid_t              mid,
  output logic [IDX_W-1:0]                 mid_idx
);
  import rwsc_pkg::*;

  localparam int NUM_MATCH = (NUM_SPECIES < TABLE_LEN) ? NUM_SPECIES : TABLE_LEN;
  localparam int SEL_EXT_W = IDX_W + 5;

  logic                   s0_valid_r;
  logic [IN_TDATA_W-1:0]  s0_data_r;
  cmd_t                   s0_cmd_r;
  logic                   s1_valid_r;
  rwsc_mid_t              s1_r;
  logic [IDX_W-1:0]       s1_idx_r;

  logic                   s1_free;
  logic                   s0_free;

  logic signed [31:0]     code;
  logic [30:0]            energy;
  logic [31:0]            pz;
  logic [4:0]             sel;
  logic [SEL_EXT_W-1:0]   sel_ext;
  logic [31:0]            abs_pz;
  logic [32:0]            sum_w;
  logic [32:0]            diff_w;
  logic [31:0]            minus;
  logic [IDX_W-1:0]       match_idx;
  logic                   match_hit;
  rwsc_mid_t              s1_nxt;
  logic [IDX_W-1:0]       s1_idx_nxt;

  assign s1_free   = !s1_valid_r || mid_ready;
  assign s0_free   = !s0_valid_r || s1_free;
  assign in_tready = s0_free;

  always_comb begin
    code    = s0_data_r[31:0];
    energy  = s0_data_r[62:32];
    pz      = s0_data_r[94:63];
    sel     = s0_data_r[99:95];
    sel_ext = SEL_EXT_W'(sel);
    abs_pz  = pz[31] ? (~pz + 32'd1) : pz;
    sum_w   = {2'b00, energy} + {pz[31], pz};
    diff_w  = {2'b00, energy} - {pz[31], pz};
    minus   = diff_w[31:0];

    // lowest matching entry wins; scan downward so it is written last
    match_idx = IDX_W'(NUM_SPECIES);
    match_hit = 1'b0;
    for (int i = NUM_MATCH - 1; i >= 0; i--) begin
      if (code == SPECIES_CODE[i]) begin
        match_idx = IDX_W'(i);
        match_hit = 1'b1;
      end
    end

    s1_nxt.cmd     = s0_cmd_r;
    s1_nxt.pos     = {1'b0, energy} > abs_pz;
    s1_nxt.lhs     = {sum_w[31:0], {Q_FRAC{1'b0}}};
    s1_nxt.prod_lo = PROD_W'(ratio_low) * PROD_W'(minus);
    s1_nxt.prod_hi = PROD_W'(ratio_high) * PROD_W'(minus);
    s1_nxt.hit     = 1'b0;
    s1_idx_nxt     = IDX_W'(NUM_SPECIES);

    unique case (s0_cmd_r)
      CMD_PARTICLE: begin
        s1_nxt.hit = match_hit;
        s1_idx_nxt = match_idx;
      end
      CMD_READ: begin
        if (sel_ext < SEL_EXT_W'(NUM_SPECIES)) begin
          s1_nxt.hit = 1'b1;
          s1_idx_nxt = sel_ext[IDX_W-1:0];
        end
      end
      CMD_END_EVENT, CMD_NOP: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (s0_free) begin
        s0_valid_r <= in_tvalid;
      end
      if (s1_free) begin
        s1_valid_r <= s0_valid_r;
      end
    end
  end

  // payload: hold while the stage is stalled
  always_ff @(posedge clk) begin
    if (s0_free && in_tvalid) begin
      s0_data_r <= in_tdata;
      s0_cmd_r  <= cmd_t'(in_tuser);
    end
    if (s1_free && s0_valid_r) begin
      s1_r     <= s1_nxt;
      s1_idx_r <= s1_idx_nxt;
    end
  end

  assign mid_valid = s1_valid_r;
  assign mid       = s1_r;
  assign mid_idx   = s1_idx_r;

endmodule

[design/rwsc_tally.sv]
// ----------------------------------------------------------------------------
// rwsc_tally: window compare, counter update and result register
// Finishes the rapidity test, updates the saturating species and event
// counters and holds the result transaction until it is taken.
// ----------------------------------------------------------------------------
module rwsc_tally #(
  parameter int NUM_SPECIES = rwsc_pkg::NUM_SPECIES_DEF,
  parameter int COUNT_WIDTH = rwsc_pkg::COUNT_WIDTH_DEF,
  parameter int IDX_W       = $clog2(NUM_SPECIES + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             mid_valid,
  output logic                             mid_ready,
  input  rwsc_pkg::rwsc_mid_t              mid,
  input  logic [IDX_W-1:0]                 mid_idx,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rwsc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rwsc_pkg::*;

  localparam int ADDR_W  = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1;
  localparam int IDX_X_W = IDX_W + 5;
  localparam int CNT_X_W = COUNT_WIDTH + 32;

  logic [COUNT_WIDTH-1:0] count_r [NUM_SPECIES];
  logic [EVENT_W-1:0]     event_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic                   advance;
  logic [ADDR_W-1:0]      addr;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] inc;
  logic                   pass;
  logic                   acc;
  logic                   wr_en;
  logic [IDX_W-1:0]       idx_out;
  logic [COUNT_WIDTH-1:0] cnt_out;
  logic [EVENT_W-1:0]     event_nxt;
  logic [IDX_X_W-1:0]     idx_x;
  logic [CNT_X_W-1:0]     cnt_x;
  logic [OUT_TDATA_W-1:0] out_data_nxt;

  assign mid_ready = !out_valid_r || out_tready;
  assign advance   = mid_valid && mid_ready;
  assign addr      = mid_idx[ADDR_W-1:0];

  always_comb begin
    cur  = mid.hit ? count_r[addr] : '0;
    inc  = (cur == {COUNT_WIDTH{1'b1}}) ? cur : cur + 1'b1;
    pass = mid.hit && mid.pos && (mid.lhs >= mid.prod_lo) && (mid.lhs < mid.prod_hi);

    acc       = 1'b0;
    wr_en     = 1'b0;
    idx_out   = mid_idx;
    cnt_out   = cur;
    event_nxt = event_r;

    unique case (mid.cmd)
      CMD_PARTICLE: begin
        acc   = pass;
        wr_en = pass;
        if (pass) begin
          cnt_out = inc;
        end
      end
      CMD_END_EVENT: begin
        if (event_r != {EVENT_W{1'b1}}) begin
          event_nxt = event_r + 1'b1;
        end
      end
      CMD_READ, CMD_NOP: begin
      end
    endcase

    // report low bits of the index and the count
    idx_x        = IDX_X_W'(idx_out);
    cnt_x        = CNT_X_W'(cnt_out);
    out_data_nxt = {2'b00, event_nxt, cnt_x[31:0], idx_x[4:0], acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      event_r     <= '0;
      for (int i = 0; i < NUM_SPECIES; i++) begin
        count_r[i] <= '0;
      end
    end else begin
      if (mid_ready) begin
        out_valid_r <= mid_valid;
      end
      if (advance) begin
        event_r <= event_nxt;
        if (wr_en) begin
          count_r[addr] <= inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[design/rwsc_checker.sv]
// ----------------------------------------------------------------------------
// rwsc_checker: port-level checks of the species counter
// Watches the result channel for stalls, reset behavior and the coding of
// unmatched and counted results.
// ----------------------------------------------------------------------------
module rwsc_checker #(
  parameter int NUM_SPECIES = rwsc_pkg::NUM_SPECIES_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rwsc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rwsc_pkg::*;

  localparam logic [4:0] NO_MATCH = 5'(NUM_SPECIES);
  localparam bit         IDX_FITS = (NUM_SPECIES < 32);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a counted particle always names a real species
  a_acc_index: assert property (@(posedge clk) disable iff (!rst_n)
    IDX_FITS && out_tvalid && out_tdata[0] |-> out_tdata[5:1] != NO_MATCH)
    else $error("counted particle without species");

  // no species: no count and not counted
  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    IDX_FITS && out_tvalid && out_tdata[5:1] == NO_MATCH
      |-> out_tdata[37:6] == 32'd0 && !out_tdata[0])
    else $error("unmatched result carries a count");

endmodule

bind rapidity_window_species_counter rwsc_checker #(
  .NUM_SPECIES (NUM_SPECIES)
) u_rwsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[bench/rapidity_window_species_counter_tb.sv]
// ----------------------------------------------------------------------------
// rapidity_window_species_counter_tb: self-checking bench for the y-window counter
// Streams particle, end-of-event, read and no-op commands through the block
// with random sender gaps and receiver stalls, and one long receiver hold-off.
// A local tally model predicts every result and checks it field by field.
// Window ratios are rewritten between phases, including the extremes.
// ----------------------------------------------------------------------------
module rapidity_window_species_counter_tb;
  import rwsc_pkg::*;

  localparam int NSPEC       = NUM_SPECIES_DEF;
  localparam int DUT_LATENCY = 3;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    cmd_t        cmd;
    logic [4:0]  sel;
    logic [31:0] pz;
    logic [30:0] energy;
    logic [31:0] pdg;
  } track_t;

  typedef struct packed {
    logic        accepted;
    logic [4:0]  species;
    logic [31:0] count;
    logic [31:0] events;
  } tally_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [RATIO_W-1:0]     cfg_wdata = '0;

  // Tally model state
  logic [31:0] species_tally [NSPEC];
  logic [31:0] event_tally;
  logic [63:0] ratio_low_q  = 64'(RATIO_LOW_RST);
  logic [63:0] ratio_high_q = 64'(RATIO_HIGH_RST);

  track_t pending_tracks [$];
  tally_t expected_tallies [$];
  int     tracks_queued   = 0;
  int     tracks_accepted = 0;
  int     errors          = 0;
  int     cycle_cnt       = 0;
  int     send_idle_pct   = 0;
  int     recv_stall_pct  = 0;
  int     hold_left       = 0;
  bit     hold_req        = 1'b0;
  bit     in_taken        = 1'b0;

  rapidity_window_species_counter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  initial begin
    for (int i = 0; i < NSPEC; i++) species_tally[i] = '0;
    event_tally = '0;
  end

  // Apply one command to the tally model and return the result it should give
  function automatic tally_t predict_tally(track_t t);
    tally_t             r;
    logic signed [63:0] e, pz, apz;
    logic [63:0]        plus, minus, lhs;
    int                 hit;
    r.accepted = 1'b0;
    r.species  = 5'(NSPEC);
    r.count    = '0;
    hit        = NSPEC;
    case (t.cmd)
      CMD_PARTICLE: begin
        for (int i = NSPEC - 1; i >= 0; i--)
          if (SPECIES_CODE[i] == t.pdg) hit = i;
        if (hit < NSPEC) begin
          e   = {33'b0, t.energy};
          pz  = {{32{t.pz[31]}}, t.pz};
          apz = (pz < 0) ? -pz : pz;
          r.species = 5'(hit);
          if (e > apz) begin
            plus  = e + pz;
            minus = e - pz;
            lhs   = plus << Q_FRAC;
            if (lhs >= ratio_low_q * minus && lhs < ratio_high_q * minus) begin
              r.accepted = 1'b1;
              if (species_tally[hit] != '1) species_tally[hit]++;
            end
          end
          r.count = species_tally[hit];
        end
      end
      CMD_END_EVENT: begin
        if (event_tally != '1) event_tally++;
      end
      CMD_READ: begin
        if (t.sel < NSPEC) begin
          r.species = t.sel;
          r.count   = species_tally[t.sel];
        end
      end
      default: ;
    endcase
    r.events = event_tally;
    return r;
  endfunction

  function automatic track_t mk_track(cmd_t c, logic [31:0] pdg, logic [30:0] e,
                                      logic [31:0] pz, logic [4:0] sel);
    track_t t;
    t.cmd = c; t.pdg = pdg; t.energy = e; t.pz = pz; t.sel = sel;
    return t;
  endfunction

  // Mostly physical particles of known species near the window, with noise
  function automatic track_t rand_track();
    track_t      t;
    int unsigned r, k, mag;
    logic [30:0] mask;
    t.pdg    = $urandom;
    t.energy = 31'($urandom);
    t.pz     = $urandom;
    t.sel    = 5'($urandom);
    r = $urandom_range(0, 99);
    if (r < 72)      t.cmd = CMD_PARTICLE;
    else if (r < 84) t.cmd = CMD_END_EVENT;
    else if (r < 97) t.cmd = CMD_READ;
    else             t.cmd = CMD_NOP;
    if (t.cmd == CMD_PARTICLE) begin
      r = $urandom_range(0, 99);
      if (r < 75)      t.pdg = SPECIES_CODE[$urandom_range(0, TABLE_LEN - 1)];
      else if (r < 87) t.pdg = -SPECIES_CODE[$urandom_range(0, TABLE_LEN - 1)];
      if ($urandom_range(0, 99) < 70) begin
        k        = $urandom_range(0, 31);
        mask     = (k >= 31) ? '1 : 31'((64'd1 << k) - 1);
        t.energy = 31'($urandom) & mask;
        mag      = $urandom_range(32'(t.energy), 0);
        t.pz     = $urandom_range(0, 1) ? -32'(mag) : 32'(mag);
      end
    end
    return t;
  endfunction

  task automatic write_ratio(cfg_reg_t which, logic [RATIO_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= which;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (which == CFG_RATIO_LOW) ratio_low_q = 64'(val);
    else ratio_high_q = 64'(val);
  endtask

  task automatic push_track(track_t t);
    pending_tracks.push_back(t);
    tracks_queued++;
  endtask

  // Wait until every queued command is taken and every result has come back
  task automatic drain();
    @(negedge clk);
    while (tracks_accepted != tracks_queued || expected_tallies.size() != 0)
      @(negedge clk);
    repeat (DUT_LATENCY + 2) @(negedge clk);
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int n_rand, bit hold, bit directed);
    if (hold) hold_req = 1'b1;
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (directed) begin
      push_track(mk_track(CMD_PARTICLE, 32'd111, 31'd1000, 32'd0, 5'd0));
      push_track(mk_track(CMD_PARTICLE, -32'sd2212, 31'd1000, 32'd100, 5'd0));
      // E equal to |pz| on either side
      push_track(mk_track(CMD_PARTICLE, 32'd3334, 31'd100, 32'd100, 5'd0));
      push_track(mk_track(CMD_PARTICLE, 32'd211, 31'd100, -32'sd100, 5'd0));
      push_track(mk_track(CMD_PARTICLE, 32'd321, 31'd0, 32'd0, 5'd0));
      // conjugate of a self-conjugate neutral is unknown
      push_track(mk_track(CMD_PARTICLE, -32'sd111, 31'd1000, 32'd0, 5'd0));
      push_track(mk_track(CMD_PARTICLE, 32'h7FFF_FFFF, '1, 32'd0, 5'd31));
      push_track(mk_track(CMD_PARTICLE, 32'h8000_0000, 31'd0, 32'h8000_0000, 5'd0));
      push_track(mk_track(CMD_PARTICLE, 32'd2212, '1, 32'd0, 5'd0));
      push_track(mk_track(CMD_PARTICLE, 32'd2212, '1, 32'h7FFF_FFFF, 5'd0));
      push_track(mk_track(CMD_PARTICLE, -32'sd3334, '1, 32'h8000_0000, 5'd0));
      push_track(mk_track(CMD_PARTICLE, 32'd130, '1, 32'h7FFF_FFFE, 5'd0));
      push_track(mk_track(CMD_PARTICLE, 32'd310, '1, 32'h8000_0002, 5'd0));
      // exactly on the lower bound (in), on the upper bound (out), just inside
      push_track(mk_track(CMD_PARTICLE, 32'd3122, 31'd89645, -32'sd41427, 5'd0));
      push_track(mk_track(CMD_PARTICLE, -32'sd3122, 31'd243681, 32'd112609, 5'd0));
      push_track(mk_track(CMD_PARTICLE, -32'sd3122, 31'd243681, 32'd112608, 5'd0));
      push_track(mk_track(CMD_END_EVENT, '1, '1, '1, '1));
      push_track(mk_track(CMD_END_EVENT, 32'd0, 31'd0, 32'd0, 5'd0));
      push_track(mk_track(CMD_READ, 32'd0, 31'd0, 32'd0, 5'd0));
      push_track(mk_track(CMD_READ, 32'd0, 31'd0, 32'd0, 5'd24));
      push_track(mk_track(CMD_READ, 32'd0, 31'd0, 32'd0, 5'd25));
      push_track(mk_track(CMD_READ, '1, '1, '1, 5'd31));
      push_track(mk_track(CMD_NOP, '1, '1, '1, '1));
      push_track(mk_track(CMD_READ, 32'd0, 31'd0, 32'd0, 5'd13));
    end
    for (int i = 0; i < n_rand; i++) push_track(rand_track());
    drain();
  endtask

  // Sender: offer the next command once the current one is taken
  always @(negedge clk) begin : drive_in
    track_t t;
    if (rst_n && (in_taken || !in_tvalid)) begin
      in_taken = 1'b0;
      if (pending_tracks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        t = pending_tracks.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {4'b0, t.sel, t.pz, t.energy, t.pdg};
        in_tuser  <= t.cmd;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_out
    if (hold_left > 0) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : hold_count
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  always @(posedge clk) begin : take_in
    track_t t;
    if (rst_n && in_tvalid && in_tready) begin
      t.cmd    = cmd_t'(in_tuser);
      t.pdg    = in_tdata[31:0];
      t.energy = in_tdata[62:32];
      t.pz     = in_tdata[94:63];
      t.sel    = in_tdata[99:95];
      expected_tallies.push_back(predict_tally(t));
      tracks_accepted++;
      in_taken = 1'b1;
    end
  end

  task automatic report_field(string fname, longint unsigned want, longint unsigned got);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
    errors++;
  endtask

  always @(posedge clk) begin : check_out
    tally_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.accepted = out_tdata[0];
      got.species  = out_tdata[5:1];
      got.count    = out_tdata[37:6];
      got.events   = out_tdata[69:38];
      if (expected_tallies.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = expected_tallies.pop_front();
        if (got.accepted !== want.accepted) report_field("accepted", want.accepted, got.accepted);
        if (got.species !== want.species) report_field("species_index", want.species, got.species);
        if (got.count !== want.count) report_field("count_value", want.count, got.count);
        if (got.events !== want.events) report_field("event_total", want.events, got.events);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : run
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset ratios, no idling, long receiver hold-off to back up the pipe
    run_phase(0, 0, 380, 1'b1, 1'b1);

    // Widest window
    write_ratio(CFG_RATIO_LOW, '0);
    write_ratio(CFG_RATIO_HIGH, '1);
    run_phase(65, 0, 400, 1'b0, 1'b0);

    // Inverted extremes: nothing can pass
    write_ratio(CFG_RATIO_LOW, '1);
    write_ratio(CFG_RATIO_HIGH, '0);
    run_phase(0, 65, 300, 1'b0, 1'b0);

    write_ratio(CFG_RATIO_LOW, RATIO_W'($urandom_range(1000, 65536)));
    write_ratio(CFG_RATIO_HIGH, RATIO_W'($urandom_range(65536, 800000)));
    run_phase(9, 9, 400, 1'b0, 1'b0);

    write_ratio(CFG_RATIO_LOW, RATIO_W'($urandom));
    write_ratio(CFG_RATIO_HIGH, RATIO_W'($urandom));
    run_phase(0, 65, 250, 1'b0, 1'b0);

    write_ratio(CFG_RATIO_LOW, RATIO_LOW_RST);
    write_ratio(CFG_RATIO_HIGH, RATIO_HIGH_RST);
    run_phase(9, 9, 300, 1'b0, 1'b0);

    repeat (2 * DUT_LATENCY + 4) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
